@@ sv/dbump_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dbump_pkg;

  localparam int unsigned SIZE_W = 20;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned QUOT_W = 21;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ACT_FRONT_ALIGN     = 3'd0,
    ACT_FRONT_UNALIGNED = 3'd1,
    ACT_REAR_ALIGN      = 3'd2,
    ACT_RESET           = 3'd3,
    ACT_SET_START       = 3'd4,
    ACT_SET_END         = 3'd5,
    ACT_QUERY           = 3'd6
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE   = 1'b0,
    CFG_REGION = 1'b1
  } cfg_e;

  typedef struct packed {
    act_e              action;
    logic [SIZE_W-1:0] request_size;
    logic [SIZE_W-1:0] position;
    logic              use_region_end;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] used_bytes;
    logic [SIZE_W-1:0] free_bytes;
  } rsp_t;

  // request after the input register, with the alignment quotient ready
  typedef struct packed {
    act_e              action;
    logic [SIZE_W-1:0] size;
    logic [QUOT_W-1:0] quot;
    logic [SIZE_W-1:0] position;
    logic              to_end;
  } stage_t;

endpackage

`default_nettype wire

@@ sv/dbump_quot.sv @@
`timescale 1ns / 1ps
`default_nettype none

// floor(x / ALIGN_BYTES) by multiplication with a rounded-up reciprocal
module dbump_quot #(
  parameter int unsigned ALIGN_BYTES = 8
) (
  input  wire logic [dbump_pkg::QUOT_W-1:0] x_i,
  output logic      [dbump_pkg::QUOT_W-1:0] q_o
);

  localparam int unsigned Shift = dbump_pkg::QUOT_W + $clog2(ALIGN_BYTES);
  localparam longint unsigned Recip = ((64'd1 << Shift) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int unsigned ProdW = dbump_pkg::QUOT_W + Shift + 1;

  logic [ProdW-1:0] prod;

  assign prod = ProdW'(x_i) * ProdW'(Recip);
  assign q_o  = prod[Shift +: dbump_pkg::QUOT_W];

endmodule

`default_nettype wire

@@ sv/dbump_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbump_prep #(
  parameter int unsigned ALIGN_BYTES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire dbump_pkg::req_t   req_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output dbump_pkg::stage_t      stage_o
);

  logic                          valid_q;
  dbump_pkg::stage_t             stage_q;
  logic [dbump_pkg::QUOT_W-1:0]  round_x;
  logic [dbump_pkg::QUOT_W-1:0]  round_q;

  // size + align - 1, divided down; the execute stage multiplies back
  assign round_x = dbump_pkg::QUOT_W'(req_i.request_size)
                 + dbump_pkg::QUOT_W'(ALIGN_BYTES - 1);

  dbump_quot #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_quot (
    .x_i(round_x),
    .q_o(round_q)
  );

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q.action   <= req_i.action;
      stage_q.size     <= req_i.request_size;
      stage_q.quot     <= round_q;
      stage_q.position <= req_i.position;
      stage_q.to_end   <= req_i.use_region_end;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ sv/dbump_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbump_exec #(
  parameter int unsigned OFFSET_BITS = 20,
  parameter int unsigned ALIGN_BYTES = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dbump_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dbump_pkg::ADDR_W-1:0]      cfg_data_i,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire dbump_pkg::stage_t                 stage_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output logic                                   ok_o,
  output logic [dbump_pkg::ADDR_W-1:0]           addr_o,
  output logic [OFFSET_BITS-1:0]                 front_o,
  output logic [OFFSET_BITS-1:0]                 rear_o,
  output logic [OFFSET_BITS-1:0]                 end_o
);

  logic [dbump_pkg::ADDR_W-1:0]  base_q;
  logic [dbump_pkg::QUOT_W-1:0]  region_quot_q;
  logic [dbump_pkg::QUOT_W-1:0]  region_quot;
  logic [OFFSET_BITS-1:0]        front_q, front_d;
  logic [OFFSET_BITS-1:0]        rear_q, rear_d;
  logic                          valid_q;
  logic                          ok_q, ok_d;
  logic [dbump_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [OFFSET_BITS-1:0]        snap_front_q, snap_rear_q, snap_end_q;
  logic [31:0]                   end_full;
  logic [OFFSET_BITS-1:0]        end_off;
  logic [31:0]                   need_al;
  logic [31:0]                   need;
  logic [OFFSET_BITS-1:0]        gap;
  logic                          fits;
  logic                          pos_ok;
  logic [OFFSET_BITS-1:0]        rear_alloc;
  logic                          fire;

  // region size is held as its quotient by the alignment
  dbump_quot #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_region_quot (
    .x_i(dbump_pkg::QUOT_W'(cfg_data_i[dbump_pkg::SIZE_W-1:0])),
    .q_o(region_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= '0;
      region_quot_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dbump_pkg::CFG_BASE) begin
        base_q <= cfg_data_i;
      end else begin
        region_quot_q <= region_quot;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign fire    = valid_i && ready_o;

  assign end_full = 32'(region_quot_q) * 32'(ALIGN_BYTES);
  assign end_off  = OFFSET_BITS'(end_full);
  assign need_al  = 32'(stage_i.quot) * 32'(ALIGN_BYTES);
  assign need     = (stage_i.action == dbump_pkg::ACT_FRONT_UNALIGNED) ?
                    32'(stage_i.size) : need_al;
  assign gap        = (rear_q > front_q) ? (rear_q - front_q) : '0;
  assign fits       = need <= 32'(gap);
  assign pos_ok     = 32'(stage_i.position) <= 32'(end_off);
  assign rear_alloc = rear_q - OFFSET_BITS'(need);

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    ok_d    = 1'b0;
    addr_d  = '0;
    case (stage_i.action)
      dbump_pkg::ACT_FRONT_ALIGN, dbump_pkg::ACT_FRONT_UNALIGNED: begin
        if (fits) begin
          ok_d    = 1'b1;
          addr_d  = base_q + 32'(front_q);
          front_d = front_q + OFFSET_BITS'(need);
        end
      end
      dbump_pkg::ACT_REAR_ALIGN: begin
        if (fits) begin
          ok_d   = 1'b1;
          rear_d = rear_alloc;
          addr_d = base_q + 32'(rear_alloc);
        end
      end
      dbump_pkg::ACT_RESET: begin
        ok_d    = 1'b1;
        front_d = '0;
        rear_d  = end_off;
      end
      dbump_pkg::ACT_SET_START: begin
        if (pos_ok) begin
          ok_d    = 1'b1;
          front_d = OFFSET_BITS'(stage_i.position);
        end
      end
      dbump_pkg::ACT_SET_END: begin
        if (stage_i.to_end) begin
          ok_d   = 1'b1;
          rear_d = end_off;
        end else if (pos_ok) begin
          ok_d   = 1'b1;
          rear_d = OFFSET_BITS'(stage_i.position);
        end
      end
      dbump_pkg::ACT_QUERY: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        front_q <= front_d;
        rear_q  <= rear_d;
      end
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  // pointer snapshot after this request, for the result stage
  always_ff @(posedge clk_i) begin
    if (fire) begin
      ok_q         <= ok_d;
      addr_q       <= addr_d;
      snap_front_q <= front_d;
      snap_rear_q  <= rear_d;
      snap_end_q   <= end_off;
    end
  end

  assign valid_o = valid_q;
  assign ok_o    = ok_q;
  assign addr_o  = addr_q;
  assign front_o = snap_front_q;
  assign rear_o  = snap_rear_q;
  assign end_o   = snap_end_q;

`ifndef SYNTHESIS
  a_fail_holds_pointers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !ok_d) |=> ($stable(front_q) && $stable(rear_q)))
    else $error("rejected request moved a pointer");

  a_reset_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stage_i.action == dbump_pkg::ACT_RESET) |=>
    (front_q == '0 && rear_q == $past(end_off)))
    else $error("reset request did not restore pointers");

  a_fail_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ok_q) |-> (addr_q == '0))
    else $error("rejected request carries a block address");

  a_snapshot_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (snap_front_q == front_q && snap_rear_q == rear_q))
    else $error("result snapshot differs from pointer state");
`endif

endmodule

`default_nettype wire

@@ sv/dbump_report.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbump_report #(
  parameter int unsigned OFFSET_BITS = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic                          ok_i,
  input  wire logic [dbump_pkg::ADDR_W-1:0]  addr_i,
  input  wire logic [OFFSET_BITS-1:0]        front_i,
  input  wire logic [OFFSET_BITS-1:0]        rear_i,
  input  wire logic [OFFSET_BITS-1:0]        end_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output dbump_pkg::rsp_t                    rsp_o
);

  localparam int unsigned SumW = OFFSET_BITS + 1;

  logic                   valid_q;
  dbump_pkg::rsp_t        rsp_q, rsp_d;
  logic [OFFSET_BITS-1:0] tail;
  logic [OFFSET_BITS-1:0] gap;
  logic [SumW-1:0]        used_sum;

  // rear bytes count as zero once the rear pointer sits past the end
  assign tail     = (end_i > rear_i) ? (end_i - rear_i) : '0;
  assign gap      = (rear_i > front_i) ? (rear_i - front_i) : '0;
  assign used_sum = SumW'(front_i) + SumW'(tail);

  always_comb begin
    rsp_d.ok            = ok_i;
    rsp_d.block_address = addr_i;
    rsp_d.used_bytes    = (33'(used_sum) > 33'(dbump_pkg::COUNT_MAX)) ?
                          dbump_pkg::COUNT_MAX : dbump_pkg::SIZE_W'(used_sum);
    rsp_d.free_bytes    = (33'(gap) > 33'(dbump_pkg::COUNT_MAX)) ?
                          dbump_pkg::COUNT_MAX : dbump_pkg::SIZE_W'(gap);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

@@ sv/double_ended_bump_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// double-ended bump allocator over one region: front pointer grows up,
// rear pointer grows down from the aligned region end
// request channel (in_valid_i / in_ready_o / in_req_i): one action per request;
// allocations, pointer reset, pointer moves or a plain query
// result channel (out_valid_o / out_ready_i / out_rsp_o): exactly one result
// per request, in order: ok, block address, bytes used and free gap
// config port: cfg_we_i writes base address (index 0) or region size (index 1)
// into registers; write only while no request is in flight
// each request passes the input register, the execute register holding the
// pointers and the result register, in that order, before its result is valid
// throughput: one request per cycle while out_ready_i does not stall the pipeline;
// the pointer update is one add/compare in the execute stage, so back-to-back requests see each other's updates
// reset: pointers, base and region size go to zero, pipeline empties
// stall: a full pipeline drops ready stage by stage back to in_ready_o;
// up to three requests sit inside while out_ready_i is low
module double_ended_bump_allocator #(
  parameter int unsigned OFFSET_BITS = 20,
  parameter int unsigned ALIGN_BYTES = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dbump_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dbump_pkg::ADDR_W-1:0]      cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire dbump_pkg::req_t                   in_req_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output dbump_pkg::rsp_t                        out_rsp_o
);

  logic                          s1_valid, s1_ready;
  dbump_pkg::stage_t             s1_stage;
  logic                          s2_valid, s2_ready;
  logic                          s2_ok;
  logic [dbump_pkg::ADDR_W-1:0]  s2_addr;
  logic [OFFSET_BITS-1:0]        s2_front, s2_rear, s2_end;

  dbump_prep #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .stage_o (s1_stage)
  );

  dbump_exec #(
    .OFFSET_BITS(OFFSET_BITS),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (s1_valid),
    .ready_o    (s1_ready),
    .stage_i    (s1_stage),
    .valid_o    (s2_valid),
    .ready_i    (s2_ready),
    .ok_o       (s2_ok),
    .addr_o     (s2_addr),
    .front_o    (s2_front),
    .rear_o     (s2_rear),
    .end_o      (s2_end)
  );

  dbump_report #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_report (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .ok_i    (s2_ok),
    .addr_i  (s2_addr),
    .front_i (s2_front),
    .rear_i  (s2_rear),
    .end_i   (s2_end),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import dbump_pkg::*;

  localparam int unsigned ALIGN_BYTES = 8;
  localparam int unsigned STALL_LIMIT = 5000;

  class alloc_scoreboard;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] region;
    logic [SIZE_W-1:0] front;
    logic [SIZE_W-1:0] rear;
    rsp_t              due_rsp_q[$];
    int                errors;

    function new();
      base = '0;
      region = '0;
      front = '0;
      rear = '0;
      errors = 0;
    endfunction

    function logic [SIZE_W-1:0] region_end();
      return SIZE_W'((region / ALIGN_BYTES) * ALIGN_BYTES);
    endfunction

    function logic [SIZE_W-1:0] gap();
      return (rear > front) ? rear - front : '0;
    endfunction

    function logic [SIZE_W:0] round_up(logic [SIZE_W-1:0] v);
      return (SIZE_W + 1)'((({1'b0, v} + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
    endfunction

    function int pending();
      return due_rsp_q.size();
    endfunction

    function void set_reg(cfg_e idx, logic [ADDR_W-1:0] val);
      // offsets stay where they are, only reset or set end picks up a new end
      if (idx == CFG_BASE) base = val;
      else region = val[SIZE_W-1:0];
    endfunction

    function void note_request(req_t r);
      logic [SIZE_W:0]   need;
      logic [SIZE_W:0]   sum;
      logic [SIZE_W-1:0] e;
      logic [SIZE_W-1:0] tail;
      rsp_t              x;
      e = region_end();
      x = '0;
      case (r.action)
        ACT_FRONT_ALIGN, ACT_FRONT_UNALIGNED: begin
          need = (r.action == ACT_FRONT_ALIGN) ? round_up(r.request_size)
                                               : {1'b0, r.request_size};
          if (need <= {1'b0, gap()}) begin
            x.block_address = base + ADDR_W'(front);
            front = front + need[SIZE_W-1:0];
            x.ok = 1'b1;
          end
        end
        ACT_REAR_ALIGN: begin
          need = round_up(r.request_size);
          if (need <= {1'b0, gap()}) begin
            rear = rear - need[SIZE_W-1:0];
            x.block_address = base + ADDR_W'(rear);
            x.ok = 1'b1;
          end
        end
        ACT_RESET: begin
          front = '0;
          rear = e;
          x.ok = 1'b1;
        end
        ACT_SET_START: begin
          if (r.position <= e) begin
            front = r.position;
            x.ok = 1'b1;
          end
        end
        ACT_SET_END: begin
          if (r.use_region_end) begin
            rear = e;
            x.ok = 1'b1;
          end else if (r.position <= e) begin
            rear = r.position;
            x.ok = 1'b1;
          end
        end
        ACT_QUERY: x.ok = 1'b1;
        default: ;
      endcase
      // rear bytes count as zero while the rear pointer sits past the end
      tail = (e > rear) ? e - rear : '0;
      sum = {1'b0, front} + {1'b0, tail};
      x.used_bytes = sum[SIZE_W] ? COUNT_MAX : sum[SIZE_W-1:0];
      x.free_bytes = gap();
      due_rsp_q.push_back(x);
    endfunction

    function void compare(string name, logic [ADDR_W-1:0] exp_v, logic [ADDR_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (due_rsp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = due_rsp_q.pop_front();
      compare("ok", ADDR_W'(exp_r.ok), ADDR_W'(got.ok));
      compare("block_address", exp_r.block_address, got.block_address);
      compare("used_bytes", ADDR_W'(exp_r.used_bytes), ADDR_W'(got.used_bytes));
      compare("free_bytes", ADDR_W'(exp_r.free_bytes), ADDR_W'(got.free_bytes));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  req_t                 in_req = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  rsp_t                 out_rsp_o;

  alloc_scoreboard sb;
  int ready_mode = 0;
  int ready_left = 0;
  int ready_tick = 0;
  int idle_cycles = 0;

  double_ended_bump_allocator #(
    .OFFSET_BITS(SIZE_W),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready_o),
    .in_req_i(in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o(out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // receiver: switches between always ready, random, periodic and mostly stalled
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= ready_tick + 1;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (ready_tick % 7) > 2;
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) sb.check_result(out_rsp_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_t mk(act_e act, logic [SIZE_W-1:0] size,
                              logic [SIZE_W-1:0] pos, logic to_end);
    req_t r;
    r.action = act;
    r.request_size = size;
    r.position = pos;
    r.use_region_end = to_end;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t        r;
    int unsigned pick;
    int          g;
    int          e;
    int          s;
    r = mk(ACT_QUERY, SIZE_W'($urandom), SIZE_W'($urandom), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    g = int'(sb.gap());
    e = int'(sb.region_end());
    if (pick < 30) r.action = ACT_FRONT_ALIGN;
    else if (pick < 45) r.action = ACT_FRONT_UNALIGNED;
    else if (pick < 65) r.action = ACT_REAR_ALIGN;
    else if (pick < 70) r.action = ACT_RESET;
    else if (pick < 78) r.action = ACT_SET_START;
    else if (pick < 88) r.action = ACT_SET_END;
    else if (pick < 94) r.action = ACT_QUERY;
    else begin
      // noise: every field fully random
      r.action = act_e'(3'($urandom_range(0, 6)));
      return r;
    end
    if (pick < 65) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: s = $urandom_range(0, 40);
        6, 7: s = g + $urandom_range(0, 16) - 8;
        8: s = 0;
        default: s = int'($urandom_range(0, 32'hFFFFF));
      endcase
      if (s < 0) s = 0;
      if (s > 32'hFFFFF) s = 32'hFFFFF;
      r.request_size = SIZE_W'(s);
    end else if (pick >= 70 && pick < 88) begin
      case ($urandom_range(0, 5))
        0, 1, 2: r.position = SIZE_W'($urandom_range(0, e));
        3: r.position = SIZE_W'(e);
        4: r.position = SIZE_W'((e < 32'hFFFFF) ? e + $urandom_range(1, 16) : e);
        default: ;
      endcase
      if (r.action == ACT_SET_END) r.use_region_end = ($urandom_range(0, 9) < 3);
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [ADDR_W-1:0] base_v, input logic [SIZE_W-1:0] size_v);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_BASE;
    cfg_data <= base_v;
    @(posedge clk_i);
    sb.set_reg(CFG_BASE, base_v);
    cfg_idx <= CFG_REGION;
    cfg_data <= ADDR_W'(size_v);
    @(posedge clk_i);
    sb.set_reg(CFG_REGION, ADDR_W'(size_v));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base_v, input logic [SIZE_W-1:0] size_v,
                           input int count);
    int left;
    int burst;
    int idle;
    drain();
    set_regs(base_v, size_v);
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      while (burst > 0 && left > 0) begin
        send_req(rand_req());
        burst--;
        left--;
      end
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      // lower valid only when a gap really follows
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rear pointer still at zero from reset, region near the top of memory
    set_regs(32'hFFFF_FFF0, 20'hFFFFF);
    send_req(mk(ACT_QUERY, '0, '0, 1'b0));
    send_req(mk(ACT_FRONT_ALIGN, '0, '0, 1'b0));
    send_req(mk(ACT_FRONT_ALIGN, 20'd1, '0, 1'b0));
    send_req(mk(ACT_RESET, '1, '1, 1'b1));
    send_req(mk(ACT_FRONT_ALIGN, 20'd1, '0, 1'b0));
    send_req(mk(ACT_FRONT_UNALIGNED, 20'd3, '0, 1'b0));
    send_req(mk(ACT_FRONT_ALIGN, 20'd5, '0, 1'b0));
    send_req(mk(ACT_REAR_ALIGN, 20'd5, '0, 1'b0));
    send_req(mk(ACT_REAR_ALIGN, '1, '0, 1'b0));
    send_req(mk(ACT_FRONT_UNALIGNED, '1, '0, 1'b0));
    // exact fit closes the gap
    send_req(mk(ACT_FRONT_UNALIGNED, sb.gap(), '0, 1'b0));
    send_req(mk(ACT_FRONT_ALIGN, '0, '0, 1'b0));
    send_req(mk(ACT_FRONT_UNALIGNED, 20'd1, '0, 1'b0));
    send_req(mk(ACT_SET_START, '0, '1, 1'b0));
    // crossed pointers
    send_req(mk(ACT_SET_START, '0, sb.region_end(), 1'b0));
    send_req(mk(ACT_REAR_ALIGN, '0, '0, 1'b0));
    send_req(mk(ACT_REAR_ALIGN, 20'd1, '0, 1'b0));
    send_req(mk(ACT_QUERY, '1, '1, 1'b1));
    send_req(mk(ACT_SET_END, '0, '0, 1'b0));
    send_req(mk(ACT_SET_END, '0, '1, 1'b0));
    send_req(mk(ACT_SET_END, '0, '1, 1'b1));
    send_req(mk(ACT_SET_START, '0, '0, 1'b0));
    send_req(mk(ACT_REAR_ALIGN, sb.region_end(), '0, 1'b0));
    send_req(mk(ACT_RESET, '0, '0, 1'b0));

    run_phase(32'h0, 20'd0, 200);
    run_phase($urandom, 20'd5, 150);
    run_phase(32'hFFFF_FFFF, 20'hFFFFF, 250);
    run_phase($urandom, 20'd64, 250);
    run_phase($urandom, SIZE_W'($urandom), 250);
    run_phase(32'hFFFF_F000, 20'd300, 250);
    run_phase(32'h0, 20'hFFFF8, 200);
    run_phase($urandom, SIZE_W'($urandom_range(1, 4096)), 200);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
